/* rtl/integer_expression_alu_macros.svh */
// Assertion macros used by the checker file.
`ifndef INTEGER_EXPRESSION_ALU_MACROS_SVH
`define INTEGER_EXPRESSION_ALU_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define IEA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define IEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/iea_pkg.sv */
// Package with request/result types, opcodes, status codes and state enums.
package iea_pkg;
    localparam int unsigned DataWidth = 64;
    localparam int unsigned W = 64;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_POW = 5'd5, OP_NEG = 5'd6, OP_EQ = 5'd7, OP_NE = 5'd8, OP_LT = 5'd9,
        OP_LE = 5'd10, OP_GT = 5'd11, OP_GE = 5'd12, OP_AND = 5'd13, OP_OR = 5'd14,
        OP_NOT = 5'd15, OP_RUP = 5'd16, OP_GCD = 5'd17, OP_LCM = 5'd18,
        OP_ABS = 5'd19, OP_SEL = 5'd20, OP_NZ = 5'd21
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_DOMAIN = 2'd2;

    typedef struct packed {
        logic [4:0] mode;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
        logic condition;
    } t_req;

    typedef struct packed {
        logic signed [W-1:0] result;
        logic [1:0] status;
    } t_rsp;

    // Classified work handed from the front to the back.
    typedef enum logic [2:0] {
        K_DONE, K_MUL, K_DIV, K_POW, K_RUP, K_GCD
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic [4:0] mode;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] res;
        logic [1:0] status;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIVSET, S_DIV, S_DIVFIX, S_POWSQ, S_RUPMUL, S_GCDDIV,
        S_LCMMUL, S_OUT
    } t_state;
endpackage

/* rtl/iea_front.sv */
// Front end: sign-reduces operands, finishes simple ops, classifies the rest.
module iea_front #(
    parameter int unsigned DATA_WIDTH = iea_pkg::DataWidth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iea_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output iea_pkg::t_job  o_job
);
    localparam int unsigned W = iea_pkg::W;
    logic          r_valid, n_valid;
    iea_pkg::t_job r_job, n_job;
    logic [W-1:0]  a, b, s;
    logic          ta, tb, lt_ab, lt_ba;

    function automatic logic [W-1:0] sxw(input logic [W-1:0] x);
        logic [W-1:0] m;
        m = {W{1'b1}} >> (W - DATA_WIDTH);
        x = x & m;
        return (x ^ (m ^ (m >> 1))) - (m ^ (m >> 1));
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job = r_job;

    always_comb begin
        a = sxw(i_req.operand_a);
        b = sxw(i_req.operand_b);
        ta = a != '0;
        tb = b != '0;
        lt_ab = $signed(a) < $signed(b);
        lt_ba = $signed(b) < $signed(a);
        s = '0;
        n_job.kind = iea_pkg::K_DONE;
        n_job.mode = i_req.mode;
        n_job.a = a;
        n_job.b = b;
        n_job.res = '0;
        n_job.status = iea_pkg::ST_OK;
        unique case (i_req.mode)
            iea_pkg::OP_ADD: n_job.res = sxw(a + b);
            iea_pkg::OP_SUB: n_job.res = sxw(a - b);
            iea_pkg::OP_MUL: n_job.kind = iea_pkg::K_MUL;
            iea_pkg::OP_DIV, iea_pkg::OP_MOD: begin
                if (!tb) n_job.status = iea_pkg::ST_DIVZ;
                else n_job.kind = iea_pkg::K_DIV;
            end
            iea_pkg::OP_POW: begin
                if (b[W-1] || !tb) n_job.res = W'(1);
                else n_job.kind = iea_pkg::K_POW;
            end
            iea_pkg::OP_NEG: n_job.res = sxw(-a);
            iea_pkg::OP_EQ: n_job.res = W'(a == b);
            iea_pkg::OP_NE: n_job.res = W'(a != b);
            iea_pkg::OP_LT: n_job.res = W'(lt_ab);
            iea_pkg::OP_LE: n_job.res = W'(!lt_ba);
            iea_pkg::OP_GT: n_job.res = W'(lt_ba);
            iea_pkg::OP_GE: n_job.res = W'(!lt_ab);
            iea_pkg::OP_AND: n_job.res = W'(ta && tb);
            iea_pkg::OP_OR: n_job.res = W'(ta || tb);
            iea_pkg::OP_NOT: n_job.res = W'(!ta);
            iea_pkg::OP_RUP: begin
                if (b[W-1] || !tb) begin
                    n_job.status = iea_pkg::ST_DOMAIN;
                end else begin
                    s = sxw(a + b - W'(1));
                    n_job.a = s;
                    n_job.kind = iea_pkg::K_RUP;
                end
            end
            iea_pkg::OP_GCD, iea_pkg::OP_LCM: begin
                if (a[W-1] || !ta || b[W-1] || !tb) n_job.status = iea_pkg::ST_DOMAIN;
                else n_job.kind = iea_pkg::K_GCD;
            end
            iea_pkg::OP_ABS: n_job.res = a[W-1] ? sxw(-a) : a;
            iea_pkg::OP_SEL: n_job.res = i_req.condition ? a : b;
            iea_pkg::OP_NZ: n_job.res = W'(ta);
            default: n_job.res = '0;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ready) n_valid = 1'b0;
        if (i_valid && o_ready) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) r_job <= n_job;
    end
endmodule

/* rtl/iea_mul.sv */
// Multi-cycle wrapping multiplier: 16x64 partial product per cycle.
module iea_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [iea_pkg::W-1:0]    i_x,
    input  logic [iea_pkg::W-1:0]    i_y,
    output logic                     o_done,
    output logic [iea_pkg::W-1:0]    o_p
);
    localparam int unsigned W = iea_pkg::W;
    logic [W-1:0] r_acc, r_x, r_y;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic [W-1:0] pp;

    assign pp = r_x * W'(r_y[15:0]);
    assign o_done = r_done;
    assign o_p = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_acc <= '0;
            r_x <= i_x;
            r_y <= i_y;
        end else if (r_busy) begin
            r_acc <= r_acc + pp;
            r_x <= r_x << 16;
            r_y <= r_y >> 16;
        end
    end
endmodule

/* rtl/iea_back.sv */
// Back end: sequencer running multiply, divide, modulo, power, round-up, gcd and lcm on shared units.
module iea_back #(
    parameter int unsigned DATA_WIDTH = iea_pkg::DataWidth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iea_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output iea_pkg::t_rsp  o_rsp
);
    localparam int unsigned W = iea_pkg::W;
    iea_pkg::t_state r_st, n_st;
    iea_pkg::t_job   r_job;
    logic [W-1:0]    r_x, r_y, r_q, r_rem, r_acc, r_res;
    logic [6:0]      r_i;
    logic            r_neg_q, r_neg_r;
    logic            mul_start, mul_done;
    logic [W-1:0]    mul_x, mul_y, mul_p;
    logic [W:0]      trial;
    logic [W-1:0]    rem_sh;
    logic            in_take;

    function automatic logic [W-1:0] sxw(input logic [W-1:0] x);
        logic [W-1:0] m;
        m = {W{1'b1}} >> (W - DATA_WIDTH);
        x = x & m;
        return (x ^ (m ^ (m >> 1))) - (m ^ (m >> 1));
    endfunction

    iea_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_x(mul_x), .i_y(mul_y), .o_done(mul_done), .o_p(mul_p)
    );

    assign o_ready = r_st == iea_pkg::S_IDLE;
    assign in_take = i_valid && o_ready;
    assign o_valid = r_st == iea_pkg::S_OUT;
    assign o_rsp.result = r_res;
    assign o_rsp.status = r_job.status;
    assign rem_sh = {r_rem[W-2:0], r_q[W-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, r_y};

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            iea_pkg::S_IDLE: if (i_valid) begin
                unique case (i_job.kind)
                    iea_pkg::K_DONE: n_st = iea_pkg::S_OUT;
                    iea_pkg::K_MUL: n_st = iea_pkg::S_MUL;
                    iea_pkg::K_POW: n_st = iea_pkg::S_POWSQ;
                    default: n_st = iea_pkg::S_DIVSET;
                endcase
            end
            iea_pkg::S_MUL: if (mul_done) begin
                priority if (r_job.kind == iea_pkg::K_POW) n_st = iea_pkg::S_POWSQ;
                else n_st = iea_pkg::S_OUT;
            end
            iea_pkg::S_POWSQ: if (mul_done) begin
                priority if (r_y == '0) n_st = iea_pkg::S_OUT;
                else if (r_y[0]) n_st = iea_pkg::S_MUL;
                else n_st = iea_pkg::S_POWSQ;
            end
            iea_pkg::S_DIVSET: n_st = iea_pkg::S_DIV;
            iea_pkg::S_DIV: if (r_i == 7'd0) n_st = iea_pkg::S_DIVFIX;
            iea_pkg::S_DIVFIX: begin
                priority case (r_job.kind)
                    iea_pkg::K_RUP: n_st = iea_pkg::S_RUPMUL;
                    iea_pkg::K_GCD: n_st = iea_pkg::S_GCDDIV;
                    default: n_st = iea_pkg::S_OUT;
                endcase
            end
            iea_pkg::S_RUPMUL: if (mul_done) n_st = iea_pkg::S_OUT;
            iea_pkg::S_GCDDIV: begin
                priority if (r_rem == '0 && r_job.mode == iea_pkg::OP_LCM)
                    n_st = iea_pkg::S_LCMMUL;
                else if (r_rem == '0) n_st = iea_pkg::S_OUT;
                else n_st = iea_pkg::S_DIVSET;
            end
            iea_pkg::S_LCMMUL: if (mul_done) n_st = iea_pkg::S_DIVSET;
            iea_pkg::S_OUT: if (i_ready) n_st = iea_pkg::S_IDLE;
            default: n_st = iea_pkg::S_IDLE;
        endcase
    end

    // Multiplier launches.
    always_comb begin
        mul_start = 1'b0;
        mul_x = r_x;
        mul_y = r_x;
        unique case (r_st)
            iea_pkg::S_IDLE: begin
                mul_start = in_take && (i_job.kind == iea_pkg::K_MUL
                                        || i_job.kind == iea_pkg::K_POW);
                mul_x = i_job.a;
                mul_y = i_job.kind == iea_pkg::K_POW ? W'(1) : i_job.b;
            end
            iea_pkg::S_MUL: begin
                mul_start = mul_done && r_job.kind == iea_pkg::K_POW;
                mul_x = r_x;
                mul_y = r_x;
            end
            iea_pkg::S_POWSQ: begin
                // the base just produced feeds the next multiply or square
                mul_start = mul_done && r_y != '0;
                mul_x = r_y[0] ? r_acc : mul_p;
                mul_y = mul_p;
            end
            iea_pkg::S_DIVFIX: begin
                mul_start = r_job.kind == iea_pkg::K_RUP;
                mul_x = r_neg_q ? -r_q : r_q;
                mul_y = r_job.b;
            end
            iea_pkg::S_GCDDIV: begin
                mul_start = r_rem == '0 && r_job.mode == iea_pkg::OP_LCM;
                mul_x = r_job.a;
                mul_y = r_job.b;
            end
            default: mul_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= iea_pkg::S_IDLE;
        end else begin
            r_st <= n_st;
        end
        unique case (r_st)
            iea_pkg::S_IDLE: if (in_take) begin
                r_job <= i_job;
                r_res <= i_job.res;
                r_x <= i_job.a;
                r_y <= i_job.b;
                r_acc <= W'(1);
            end
            iea_pkg::S_MUL: if (mul_done) begin
                r_res <= sxw(mul_p);
                r_acc <= mul_p;
                r_y <= r_y >> 1;
            end
            iea_pkg::S_POWSQ: if (mul_done) begin
                // first pass carries the initial base through (x*1)
                r_x <= mul_p;
                r_res <= sxw(r_acc);
                if (r_y != '0 && !r_y[0]) r_y <= r_y >> 1;
            end
            iea_pkg::S_DIVSET: begin
                r_neg_r <= r_x[W-1];
                r_neg_q <= r_x[W-1] ^ r_y[W-1];
                r_q <= r_x[W-1] ? -r_x : r_x;
                r_y <= r_y[W-1] ? -r_y : r_y;
                r_rem <= '0;
                r_i <= 7'(W - 1);
            end
            iea_pkg::S_DIV: begin
                r_i <= r_i - 7'd1;
                if (!trial[W]) r_rem <= trial[W-1:0];
                else r_rem <= rem_sh;
                r_q <= {r_q[W-2:0], !trial[W]};
            end
            iea_pkg::S_DIVFIX: begin
                if (r_job.mode == iea_pkg::OP_MOD) r_res <= sxw(r_neg_r ? -r_rem : r_rem);
                else r_res <= sxw(r_neg_q ? -r_q : r_q);
                if (r_job.kind == iea_pkg::K_GCD) begin
                    r_x <= r_y;
                    r_y <= r_rem;
                end
            end
            iea_pkg::S_GCDDIV: if (r_rem == '0) begin
                r_res <= r_x;
                r_acc <= r_x;
            end
            iea_pkg::S_LCMMUL: if (mul_done) begin
                r_x <= sxw(mul_p);
                r_y <= r_acc;
                r_job.kind <= iea_pkg::K_DONE;
            end
            iea_pkg::S_RUPMUL: if (mul_done) r_res <= sxw(mul_p);
            default: r_i <= r_i;
        endcase
    end
endmodule

/* rtl/integer_expression_alu.sv */
// Top level of the signed integer ALU: front classifier, job queue, back sequencer.
//  - Requests enter on i_req_valid/o_req_ready with a t_req payload
//    (mode, operand_a, operand_b, condition); results leave on
//    o_rsp_valid/i_rsp_ready with a t_rsp payload (result, status).
//  - Simple ops (add, compares, logic, select and the like) finish in the
//    front; the back only presents the result from its S_OUT state.
//  - Multiply uses a 16x64 partial-product unit.
//  - Divide and modulo use a 64-step restoring divider at any DATA_WIDTH,
//    one quotient bit per cycle; round-up adds a multiply.
//  - Power runs 1 + n + p multiplies (n exponent bits, p of them set);
//    an exponent <= 0 finishes in the front.
//  - Gcd runs a divide and a check state per Euclid step; lcm adds a
//    multiply and a final division.
//  - The back works on one request at a time; the front holds one more, so
//    a new request is taken while a result still waits. The back takes a
//    new job only from its idle state, after its result has left.
//  - Reset (synchronous, active low) empties both stages; no clearing pass.
//  - A stalled receiver holds the result and, once the front is full,
//    deasserts o_req_ready.
module integer_expression_alu #(
    parameter int unsigned DATA_WIDTH = iea_pkg::DataWidth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  iea_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output iea_pkg::t_rsp o_rsp
);
    // front to back queue entry
    logic          job_valid, job_ready;
    iea_pkg::t_job job;

    iea_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_req_valid), .o_ready(o_req_ready), .i_req(i_req),
        .o_valid(job_valid), .i_ready(job_ready), .o_job(job)
    );

    iea_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(job_valid), .o_ready(job_ready), .i_job(job),
        .o_valid(o_rsp_valid), .i_ready(i_rsp_ready), .o_rsp(o_rsp)
    );
endmodule

/* rtl/iea_checker.sv */
// Port-level checker for the ALU, bound to the top level.
`include "integer_expression_alu_macros.svh"
module iea_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_ready,
    input iea_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input iea_pkg::t_rsp o_rsp
);
    `IEA_ASSERT_NEXT(a_req_hold, i_clk, i_rst_n, i_req_valid && !o_req_ready,
        i_req_valid && $stable(i_req), "request dropped while stalled")
    `IEA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready,
        o_rsp_valid && $stable(o_rsp), "result dropped while stalled")
    `IEA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_rsp_valid,
        o_rsp.status != 2'd3, "bad status code")
    `IEA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        o_rsp_valid && o_rsp.status != iea_pkg::ST_OK,
        o_rsp.result == '0, "error result not zero")
endmodule

bind integer_expression_alu iea_port_checker u_iea_checker (.*);
